[rtl/zhr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package zhr_pkg;

  localparam int unsigned LMAX_DEF      = 31;
  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam int unsigned DEGREE_W = 5;
  localparam int unsigned COS_W    = 18;
  localparam int unsigned VALUE_W  = 19;
  localparam int unsigned SCALE_W  = VALUE_W + 2;

  localparam int unsigned COS_LIM_MAG   = 65536;
  localparam int unsigned OUT_POS_MAG   = 262143;
  localparam int unsigned OUT_NEG_MAG   = 262144;

  localparam logic [63:0] Y0_Q30 = 64'd302896976;
  localparam logic [63:0] Y1_Q30 = 64'd524632952;

  typedef struct packed {
    logic load;
    logic mul_y1;
    logic mul_a;
    logic mul_t;
    logic mul_b;
    logic update;
    logic emit;
  } zhr_cmd_t;

  typedef struct packed {
    logic deg_lt2;
    logic k_last;
    logic out_free;
  } zhr_sts_t;

  // Restoring long division: floor(num * 2^bits / den) for num below 2^32.
  function automatic logic [63:0] div_frac(input logic [63:0] num, input logic [63:0] den,
                                           input int unsigned bits);
    logic [63:0] q;
    logic [63:0] rem;
    int          i;
    q   = '0;
    rem = '0;
    for (i = 31; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      q   = {q[62:0], 1'b0};
      if (rem >= den) begin
        rem  = rem - den;
        q[0] = 1'b1;
      end
    end
    for (i = 0; i < int'(bits); i++) begin
      rem = {rem[62:0], 1'b0};
      q   = {q[62:0], 1'b0};
      if (rem >= den) begin
        rem  = rem - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] isqrt(input logic [63:0] arg);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    int          i;
    x = arg;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (i = 0; i < 32; i++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] coef_a(input int unsigned k, input int unsigned f);
    logic [63:0] kk;
    kk = 64'(k);
    return isqrt(div_frac(4 * kk * kk - 64'd1, kk * kk, 2 * f));
  endfunction

  function automatic logic [63:0] coef_b(input int unsigned k, input int unsigned f);
    logic [63:0] kk;
    kk = 64'(k);
    return isqrt(div_frac((kk - 64'd1) * (kk - 64'd1) * (2 * kk + 64'd1),
                          kk * kk * (2 * kk - 64'd3), 2 * f));
  endfunction

  // Q30 constant rounded half away from zero to f fraction bits.
  function automatic logic [63:0] const_q(input logic [63:0] q30, input int unsigned f);
    if (f >= 30) begin
      return q30;
    end
    return (q30 + (64'd1 << (29 - f))) >> (30 - f);
  endfunction

endpackage

`default_nettype wire

[rtl/zhr_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface zhr_in_if import zhr_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic        [DEGREE_W-1:0] degree;
  logic signed [COS_W-1:0]    cos_theta;

  modport source (output valid, output degree, output cos_theta, input ready);
  modport sink (input valid, input degree, input cos_theta, output ready);
endinterface

interface zhr_out_if import zhr_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

`default_nettype wire

[rtl/zhr_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module zhr_ctrl import zhr_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire zhr_sts_t sts_i,
  output zhr_cmd_t      cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b000_0001,
    S_Y1   = 7'b000_0010,
    S_A    = 7'b000_0100,
    S_T    = 7'b000_1000,
    S_B    = 7'b001_0000,
    S_FIN  = 7'b010_0000,
    S_OUT  = 7'b100_0000
  } state_e;

  state_e state_q, state_d;
  logic   pend_q, pend_d;

  always_comb begin
    state_d    = state_q;
    pend_d     = pend_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_Y1;
        end
      end
      S_Y1: begin
        cmd_o.mul_y1 = 1'b1;
        pend_d       = 1'b0;
        state_d      = sts_i.deg_lt2 ? S_OUT : S_A;
      end
      S_A: begin
        cmd_o.mul_a  = 1'b1;
        cmd_o.update = pend_q;
        pend_d       = 1'b0;
        state_d      = S_T;
      end
      S_T: begin
        cmd_o.mul_t = 1'b1;
        state_d     = S_B;
      end
      S_B: begin
        cmd_o.mul_b = 1'b1;
        pend_d      = 1'b1;
        state_d     = sts_i.k_last ? S_FIN : S_A;
      end
      S_FIN: begin
        cmd_o.update = 1'b1;
        pend_d       = 1'b0;
        state_d      = S_OUT;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

endmodule

`default_nettype wire

[rtl/zhr_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module zhr_datapath import zhr_pkg::*; #(
  parameter int unsigned LMAX      = LMAX_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire zhr_cmd_t                   cmd_i,
  output zhr_sts_t                        sts_o,
  input  wire logic        [DEGREE_W-1:0] in_degree_i,
  input  wire logic signed [COS_W-1:0]    in_cos_i,
  output logic                            out_valid_o,
  output logic signed      [VALUE_W-1:0]  out_value_o,
  input  wire logic                       out_ready_i
);

  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned KW  = $clog2(LMAX + 1);
  localparam int unsigned DW  = (KW > DEGREE_W) ? KW : DEGREE_W;
  localparam int unsigned CW  = F + 2;
  localparam int unsigned YW  = F + 5;
  localparam int unsigned TW  = F + 2;
  localparam int unsigned PW  = F + 6;
  localparam int unsigned MAW = F + 1;
  localparam int unsigned MBW = F + 4;

  localparam logic [MAW-1:0] Y0C = MAW'(const_q(Y0_Q30, F));
  localparam logic [MAW-1:0] Y1C = MAW'(const_q(Y1_Q30, F));
  localparam logic signed [PW:0] LIM_P = (PW + 1)'(64'sd1 <<< (F + 3));
  localparam logic signed [PW:0] LIM_N = -LIM_P;

  logic [MAW-1:0] rom_a [LMAX+1];
  logic [MAW-1:0] rom_b [LMAX+1];

  for (genvar gk = 0; gk <= LMAX; gk++) begin : g_rom
    if (gk < 2) begin : g_unused
      assign rom_a[gk] = '0;
      assign rom_b[gk] = '0;
    end else begin : g_coef
      assign rom_a[gk] = MAW'(coef_a(gk, F));
      assign rom_b[gk] = MAW'(coef_b(gk, F));
    end
  end

  logic        [KW-1:0] deg_q, k_q;
  logic signed [CW-1:0] c_q;
  logic signed [YW-1:0] y0_q, y1_q;
  logic signed [TW-1:0] t_q;
  logic signed [PW-1:0] p_q, q_q;
  logic signed [VALUE_W-1:0] value_q;
  logic                 valid_q;

  // Input conversion: clamp the degree to LMAX, clamp cos(theta) and rescale it to F fraction bits.
  logic        [DW-1:0]  deg_ext;
  logic        [KW-1:0]  deg_clamp;
  logic                  cin_neg;
  logic        [COS_W-1:0] cin_abs;
  logic        [16:0]    cin_mag;
  logic        [F:0]     cin_scaled;
  logic signed [CW-1:0]  c_new;

  assign deg_ext   = DW'(in_degree_i);
  assign deg_clamp = (deg_ext > DW'(LMAX)) ? KW'(LMAX) : KW'(deg_ext);
  assign cin_neg   = in_cos_i[COS_W-1];
  assign cin_abs   = cin_neg ? COS_W'(0) - COS_W'(in_cos_i) : COS_W'(in_cos_i);
  assign cin_mag   = (cin_abs > COS_W'(COS_LIM_MAG)) ? 17'(COS_LIM_MAG) : cin_abs[16:0];

  if (F >= 16) begin : g_cin_up
    assign cin_scaled = (F + 1)'(cin_mag) << (F - 16);
  end else begin : g_cin_down
    assign cin_scaled = (F + 1)'((18'(cin_mag) + (18'd1 << (15 - F))) >> (16 - F));
  end

  assign c_new = cin_neg ? CW'(0) - CW'(cin_scaled) : CW'(cin_scaled);

  // Shared sign-magnitude multiplier, product truncated by F bits.
  logic [CW-1:0]      c_abs;
  logic [YW-1:0]      y0_abs, y1_abs;
  logic [TW-1:0]      t_abs;
  logic [MAW-1:0]     ma;
  logic [MBW-1:0]     mb;
  logic               a_neg, b_neg;
  logic [MAW+MBW-1:0] prod;
  logic [PW-1:0]      prod_mag;
  logic signed [PW-1:0] mul_res;

  assign c_abs  = c_q[CW-1]  ? CW'(0) - CW'(c_q)  : CW'(c_q);
  assign y0_abs = y0_q[YW-1] ? YW'(0) - YW'(y0_q) : YW'(y0_q);
  assign y1_abs = y1_q[YW-1] ? YW'(0) - YW'(y1_q) : YW'(y1_q);
  assign t_abs  = t_q[TW-1]  ? TW'(0) - TW'(t_q)  : TW'(t_q);

  always_comb begin
    if (cmd_i.mul_y1) begin
      ma    = Y1C;
      a_neg = 1'b0;
      mb    = MBW'(c_abs);
      b_neg = c_q[CW-1];
    end else if (cmd_i.mul_a) begin
      ma    = rom_a[k_q];
      a_neg = 1'b0;
      mb    = MBW'(c_abs);
      b_neg = c_q[CW-1];
    end else if (cmd_i.mul_t) begin
      ma    = t_abs[MAW-1:0];
      a_neg = t_q[TW-1];
      mb    = y1_abs[MBW-1:0];
      b_neg = y1_q[YW-1];
    end else begin
      ma    = rom_b[k_q];
      a_neg = 1'b0;
      mb    = y0_abs[MBW-1:0];
      b_neg = y0_q[YW-1];
    end
  end

  assign prod     = (MAW + MBW)'(ma) * (MAW + MBW)'(mb);
  assign prod_mag = PW'(prod[MAW+MBW-1:F]);
  assign mul_res  = (a_neg ^ b_neg) ? PW'(0) - prod_mag : prod_mag;

  // Recurrence update with clamping to eight in magnitude.
  logic signed [PW:0]   diff;
  logic signed [PW:0]   diff_clamp;

  assign diff       = (PW + 1)'(p_q) - (PW + 1)'(q_q);
  assign diff_clamp = (diff > LIM_P) ? LIM_P : ((diff < LIM_N) ? LIM_N : diff);

  // Output: rescale to 16 fraction bits and saturate.
  logic signed [YW-1:0]  y_sel;
  logic                  y_neg;
  logic        [YW-1:0]  y_abs;
  logic        [SCALE_W-1:0] y_scaled;
  logic        [SCALE_W-1:0] y_lim;
  logic        [SCALE_W-1:0] y_sat;
  logic signed [VALUE_W-1:0] value_new;

  assign y_sel = (deg_q == '0) ? y0_q : y1_q;
  assign y_neg = y_sel[YW-1];
  assign y_abs = y_neg ? YW'(0) - YW'(y_sel) : YW'(y_sel);

  if (F > 16) begin : g_out_down
    assign y_scaled = SCALE_W'((y_abs + (YW'(1) << (F - 17))) >> (F - 16));
  end else begin : g_out_up
    assign y_scaled = SCALE_W'(y_abs) << (16 - F);
  end

  assign y_lim     = y_neg ? SCALE_W'(OUT_NEG_MAG) : SCALE_W'(OUT_POS_MAG);
  assign y_sat     = (y_scaled > y_lim) ? y_lim : y_scaled;
  assign value_new = y_neg ? VALUE_W'(SCALE_W'(0) - y_sat) : VALUE_W'(y_sat);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      deg_q <= deg_clamp;
      k_q   <= KW'(2);
      c_q   <= c_new;
      y0_q  <= YW'(Y0C);
    end
    if (cmd_i.mul_y1) begin
      y1_q <= YW'(mul_res);
    end
    if (cmd_i.mul_a) begin
      t_q <= TW'(mul_res);
    end
    if (cmd_i.mul_t) begin
      p_q <= mul_res;
    end
    if (cmd_i.mul_b) begin
      q_q <= mul_res;
      if (k_q != deg_q) begin
        k_q <= k_q + KW'(1);
      end
    end
    if (cmd_i.update) begin
      y0_q <= y1_q;
      y1_q <= YW'(diff_clamp);
    end
    if (cmd_i.emit) begin
      value_q <= value_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  assign sts_o.deg_lt2  = deg_q < KW'(2);
  assign sts_o.k_last   = k_q == deg_q;
  assign sts_o.out_free = !valid_q || out_ready_i;

  assign out_valid_o = valid_q;
  assign out_value_o = value_q;

endmodule

`default_nettype wire

[rtl/zonal_harmonic_recurrence_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel  Direction  Beat contents
// in_i     sink       degree (5 b unsigned), cos_theta (18 b signed Q1.16)
// out_o    source     value (19 b signed Q2.16, saturated)
//
// One item is worked at a time on a single shared multiplier, three products per
// recurrence degree. After acceptance the core forms y1, then for each degree from
// two up to l forms the a, t and b products and updates the recurrence, and then
// registers the result; degrees zero and one go from y1 straight to the output.
// The output register lets the next beat be accepted while a result waits.
// Reset is asynchronous and active low and clears only control state.

module zonal_harmonic_recurrence_core import zhr_pkg::*; #(
  parameter int unsigned LMAX      = LMAX_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  zhr_in_if.sink    in_i,
  zhr_out_if.source out_o
);

  zhr_cmd_t cmd;
  zhr_sts_t sts;

  zhr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  zhr_datapath #(
    .LMAX      (LMAX),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_degree_i (in_i.degree),
    .in_cos_i    (in_i.cos_theta),
    .out_valid_o (out_o.valid),
    .out_value_o (out_o.value),
    .out_ready_i (out_o.ready)
  );

endmodule

`default_nettype wire

[dv/zhr_value_checker.sv]
`timescale 1ns / 1ps

module zhr_value_checker import zhr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  zhr_in_if    req_i,
  zhr_out_if   rsp_i,
  output int   fails_o,
  output int   pending_o
);

  localparam int unsigned MAX_DEGREE = 31;
  localparam int unsigned FRAC       = 16;
  localparam longint      COS_LIMIT  = 65536;
  localparam longint      Y_LIMIT    = longint'(8) << FRAC;
  localparam longint      VALUE_HI   = 262143;
  localparam longint      VALUE_LO   = -262144;
  localparam longint      Y0_FIX     = longint'((64'd302896976 + 64'd8192) >> 14);
  localparam longint      Y1_FIX     = longint'((64'd524632952 + 64'd8192) >> 14);

  typedef struct packed {
    logic        [DEGREE_W-1:0] degree;
    logic signed [COS_W-1:0]    cos_theta;
    logic signed [VALUE_W-1:0]  value;
  } zonal_sample_t;

  zonal_sample_t zonal_expected_q[$];

  function automatic longint unsigned int_root(input longint unsigned x);
    longint unsigned r;
    longint unsigned t;
    int              b;
    r = 0;
    for (b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= x) begin
        r = t;
      end
    end
    return r;
  endfunction

  // Magnitudes are multiplied and truncated, then the sign is put back.
  function automatic longint fixed_mul(input longint a, input longint b);
    longint unsigned ma;
    longint unsigned mb;
    longint unsigned p;
    logic            neg;
    neg = (a < 0) != (b < 0);
    ma  = (a < 0) ? -a : a;
    mb  = (b < 0) ? -b : b;
    p   = (ma * mb) >> FRAC;
    return neg ? -longint'(p) : longint'(p);
  endfunction

  function automatic logic signed [VALUE_W-1:0] zonal_value(
      input logic [DEGREE_W-1:0] degree, input logic signed [COS_W-1:0] cos_theta);
    longint          c;
    longint          y;
    longint          y_prev;
    longint          y_cur;
    longint          ak;
    longint          bk;
    longint unsigned kk;
    int unsigned     l;
    int unsigned     k;
    l = 32'(degree);
    if (l > MAX_DEGREE) begin
      l = MAX_DEGREE;
    end
    c = longint'(cos_theta);
    if (c > COS_LIMIT) begin
      c = COS_LIMIT;
    end else if (c < -COS_LIMIT) begin
      c = -COS_LIMIT;
    end
    y_prev = Y0_FIX;
    y_cur  = fixed_mul(Y1_FIX, c);
    if (l == 0) begin
      y = y_prev;
    end else begin
      y = y_cur;
      for (k = 2; k <= l; k++) begin
        kk = 64'(k);
        ak = int_root(((4 * kk * kk - 1) << (2 * FRAC)) / (kk * kk));
        bk = int_root((((kk - 1) * (kk - 1) * (2 * kk + 1)) << (2 * FRAC)) /
                      (kk * kk * (2 * kk - 3)));
        y  = fixed_mul(fixed_mul(ak, c), y_cur) - fixed_mul(bk, y_prev);
        if (y > Y_LIMIT) begin
          y = Y_LIMIT;
        end else if (y < -Y_LIMIT) begin
          y = -Y_LIMIT;
        end
        y_prev = y_cur;
        y_cur  = y;
      end
    end
    if (y > VALUE_HI) begin
      y = VALUE_HI;
    end else if (y < VALUE_LO) begin
      y = VALUE_LO;
    end
    return y[VALUE_W-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    fails_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    zonal_sample_t got;
    zonal_sample_t want;
    if (!rst_ni) begin
      zonal_expected_q.delete();
      pending_o <= 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (zonal_expected_q.size() == 0) begin
          report_mismatch($sformatf("result beat value=%0d with nothing expected",
                                    rsp_i.value));
        end else begin
          want = zonal_expected_q.pop_front();
          if (rsp_i.value !== want.value) begin
            report_mismatch($sformatf("degree=%0d cos_theta=%0d value=%0d, expected %0d",
                                      want.degree, want.cos_theta, rsp_i.value, want.value));
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        got.degree    = req_i.degree;
        got.cos_theta = req_i.cos_theta;
        got.value     = zonal_value(req_i.degree, req_i.cos_theta);
        zonal_expected_q.push_back(got);
      end
      pending_o <= zonal_expected_q.size();
    end
  end

endmodule

[dv/tb_zonal_harmonic_recurrence_core.sv]
`timescale 1ns / 1ps

module tb_zonal_harmonic_recurrence_core;
  import zhr_pkg::*;

  logic clk;
  logic rst_n;
  int   fails;
  int   pending;
  bit   quiet;
  bit   hold_req;

  int unsigned dir_deg[5]  = '{0, 1, 2, 3, 31};
  int          dir_edge[3] = '{65536, -65536, 0};
  int          dir_odd[8]  = '{131071, -131072, 65537, -65537, 1, -1, 32768, -32768};

  zhr_in_if  in_if ();
  zhr_out_if out_if ();

  zonal_harmonic_recurrence_core DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  zhr_value_checker u_check (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .req_i    (in_if),
    .rsp_i    (out_if),
    .fails_o  (fails),
    .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_beat(input logic [DEGREE_W-1:0] degree,
                           input logic signed [COS_W-1:0] cos_theta);
    in_if.valid     <= 1'b1;
    in_if.degree    <= degree;
    in_if.cos_theta <= cos_theta;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic sender_gap(input int cycles);
    in_if.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic signed [COS_W-1:0] random_cos();
    case ($urandom_range(0, 9))
      0: return COS_W'($urandom);
      1: begin
        if ($urandom_range(0, 1) == 1) begin
          return COS_W'(65536 - int'($urandom_range(0, 3)));
        end
        return COS_W'(-65536 + int'($urandom_range(0, 3)));
      end
      default: return COS_W'(int'($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  initial begin
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (quiet || $urandom_range(0, 2) != 0) begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
  end

  initial begin
    int  i;
    int  j;
    bit  busy_stretch;
    rst_n           <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.degree    <= '0;
    in_if.cos_theta <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < 5; i++) begin
      for (j = 0; j < 3; j++) begin
        if ($urandom_range(0, 2) == 0) begin
          sender_gap($urandom_range(1, 15));
        end
        send_beat(DEGREE_W'(dir_deg[i]), COS_W'(dir_edge[j]));
      end
    end
    for (i = 0; i < 8; i++) begin
      send_beat(DEGREE_W'((i % 2 == 0) ? 31 : i), COS_W'(dir_odd[i]));
    end
    drain_results();

    for (i = 0; i < 550; i++) begin
      if (i == 150) begin
        drain_results();
      end
      if (i == 250) begin
        hold_req = 1'b1;
      end
      if (i >= 470) begin
        quiet = 1'b1;
      end
      busy_stretch = (i >= 80 && i < 130) || (i >= 250 && i < 290);
      if (!quiet && !busy_stretch && $urandom_range(0, 3) == 0) begin
        sender_gap($urandom_range(1, 15));
      end
      send_beat(DEGREE_W'($urandom_range(0, 31)), random_cos());
    end
    drain_results();
    repeat (100) @(posedge clk);

    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
